// ----- sv/cltc_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the
// cell location TTL cache. No dependencies.
`default_nettype none
package cltc_pkg;

  // Slot store geometry
  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int MCC_W   = 10;
  localparam int MNC_W   = 10;
  localparam int LAC_W   = 16;
  localparam int CID_W   = 28;
  localparam int RADIO_W = 3;
  localparam int KEY_W   = MCC_W + MNC_W + LAC_W + CID_W;
  localparam int TIME_W  = 32;
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int RANGE_W = 16;
  localparam int SLOT_W  = 10;
  localparam int TTL_W   = 32;
  localparam int CAP_W   = 11;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int TAG_W   = KEY_W + RADIO_W;
  localparam int LOC_W   = LAT_W + LON_W + RANGE_W;

  // Configuration
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  localparam logic [TTL_W-1:0] TTL_RESET = 32'd86400;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTL      = 1'b0,
    REG_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_run;
    logic finish;
    logic in_ready;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- sv/cltc_ifs.sv -----
// Handshake channel interfaces of the cell location TTL cache: request,
// response and configuration write. Depends on cltc_pkg.
`default_nettype none
interface cltc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [cltc_pkg::MCC_W-1:0]         mcc;
  logic [cltc_pkg::MNC_W-1:0]         mnc;
  logic [cltc_pkg::LAC_W-1:0]         lac;
  logic [cltc_pkg::CID_W-1:0]         cell_id;
  logic [cltc_pkg::RADIO_W-1:0]       radio;
  logic [cltc_pkg::TIME_W-1:0]        now_seconds;
  logic signed [cltc_pkg::LAT_W-1:0]  latitude;
  logic signed [cltc_pkg::LON_W-1:0]  longitude;
  logic [cltc_pkg::RANGE_W-1:0]       range_m;

  modport source (output valid, cmd, mcc, mnc, lac, cell_id, radio, now_seconds,
                  latitude, longitude, range_m, input ready);
  modport sink   (input valid, cmd, mcc, mnc, lac, cell_id, radio, now_seconds,
                  latitude, longitude, range_m, output ready);
endinterface

interface cltc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [cltc_pkg::LAT_W-1:0]  hit_latitude;
  logic signed [cltc_pkg::LON_W-1:0]  hit_longitude;
  logic [cltc_pkg::RANGE_W-1:0]       hit_range_m;
  logic [cltc_pkg::SLOT_W-1:0]        slot;

  modport source (output valid, hit, hit_latitude, hit_longitude, hit_range_m, slot,
                  input ready);
  modport sink   (input valid, hit, hit_latitude, hit_longitude, hit_range_m, slot,
                  output ready);
endinterface

interface cltc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cltc_pkg::CFG_IDX_W-1:0]  index;
  logic [cltc_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/cell_location_ttl_cache.sv -----
// Top level of the cell location TTL cache: controller plus datapath.
// Depends on cltc_pkg, cltc_ifs, cltc_ctrl, cltc_dp and cltc_ram.
//
// Usage:
//   req carries one lookup (cmd 0) or insert (cmd 1) per transfer: the cell
//   key, the current time and, for inserts, the location to store. rsp
//   returns one result per request in request order. cfg writes ttl_seconds
//   (index 0) and capacity (index 1); it is always ready and must be used
//   only while the cache is idle.
//   Each request scans the filled slots one per cycle through the tag and
//   insertion time stores, then fetches the expiry and location of the
//   matched slot and commits the result to the output register; the next
//   request is taken only after that result is loaded.
//   A finished result waits in the output register while the next request
//   is taken and scanned; if the receiver still stalls when that request is
//   done, the cache holds it until the output register frees.
//   Reset empties the cache (fill count zero) and restores the register
//   defaults (ttl 86400 s, capacity 1000); no clearing pass is needed.
`default_nettype none
module cell_location_ttl_cache (
  input  wire logic  clk,
  input  wire logic  rst,
  cltc_req_if.sink   req,
  cltc_rsp_if.source rsp,
  cltc_cfg_if.sink   cfg
);

  cltc_pkg::ctrl_t   ctl;
  cltc_pkg::status_t sts;

  cltc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  cltc_dp u_dp (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // A miss carries no location and slot zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.slot == '0 && rsp.hit_range_m == '0 &&
                                 rsp.hit_latitude == '0 && rsp.hit_longitude == '0))
    else $error("miss result carries nonzero fields");

  // A result never appears in the cycle after a request transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !$rose(rsp.valid))
    else $error("result loaded too soon after request");

  // A new result is loaded only while requests are held off
  a_busy_on_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> !$past(req.ready))
    else $error("result loaded while cache was idle");

endmodule
`default_nettype wire

// ----- sv/cltc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none
module cltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/cltc_ctrl.sv -----
// Controller of the cell location TTL cache: sequences capture, slot
// scan, fetch and commit. Depends on cltc_pkg.
`default_nettype none
module cltc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire cltc_pkg::status_t sts,
  output cltc_pkg::ctrl_t        ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  state_t state;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (req_valid) state <= ST_SCAN;
        ST_SCAN:   if (sts.scan_done) state <= ST_FETCH;
        ST_FETCH:  state <= ST_FINISH;
        ST_FINISH: if (sts.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Decode commands
  always_comb begin
    ctl.in_ready = (state == ST_IDLE);
    ctl.capture  = (state == ST_IDLE) && req_valid;
    ctl.scan_run = (state == ST_SCAN);
    ctl.finish   = (state == ST_FINISH) && sts.out_free;
  end

endmodule
`default_nettype wire

// ----- sv/cltc_dp.sv -----
// Datapath of the cell location TTL cache: item and config registers,
// slot stores, scan compare, replacement choice and response register.
// Depends on cltc_pkg, cltc_ifs and cltc_ram.
`default_nettype none
module cltc_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cltc_pkg::ctrl_t ctl,
  output cltc_pkg::status_t    sts,
  cltc_req_if.sink             req,
  cltc_rsp_if.source           rsp,
  cltc_cfg_if.sink             cfg
);

  localparam int AW = cltc_pkg::ADDR_W;
  localparam int CW = cltc_pkg::CNT_W;
  localparam int MW = cltc_pkg::CMP_W;

  // Configuration registers
  logic [cltc_pkg::TTL_W-1:0] ttl;
  logic [cltc_pkg::CAP_W-1:0] capacity;

  // Captured item
  logic                         op_q;
  logic [cltc_pkg::TAG_W-1:0]   tag_q;
  logic [cltc_pkg::TIME_W-1:0]  now_q;
  logic [cltc_pkg::LOC_W-1:0]   loc_q;

  // Scan state
  logic [CW-1:0]               fill;
  logic [CW-1:0]               scan_addr;
  logic                        pend;
  logic [AW-1:0]               addr_d;
  logic                        found;
  logic [AW-1:0]               found_slot;
  logic [AW-1:0]               best_slot;
  logic [cltc_pkg::TIME_W-1:0] best_time;

  // Store read data
  logic [cltc_pkg::TAG_W-1:0]  tag_rd;
  logic [cltc_pkg::TIME_W-1:0] ins_rd;
  logic [cltc_pkg::TIME_W-1:0] exp_rd;
  logic [cltc_pkg::LOC_W-1:0]  loc_rd;

  // Commit signals
  logic                        issue;
  logic                        tag_match;
  logic [MW-1:0]               eff_cap;
  logic                        take_new;
  logic [AW-1:0]               wr_slot;
  logic [cltc_pkg::TIME_W:0]   exp_sum;
  logic [cltc_pkg::TIME_W-1:0] exp_val;
  logic                        we;
  logic                        lk_hit;

  // Response register
  logic                          out_valid;
  logic                          out_hit;
  logic [cltc_pkg::LOC_W-1:0]    out_loc;
  logic [cltc_pkg::SLOT_W-1:0]   out_slot;

  // Take configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl      <= cltc_pkg::TTL_RESET;
      capacity <= cltc_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      unique case (cltc_pkg::cfg_reg_t'(cfg.index))
        cltc_pkg::REG_TTL:      ttl      <= cfg.data;
        cltc_pkg::REG_CAPACITY: capacity <= cfg.data[cltc_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the item on transfer
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_q  <= req.cmd;
      tag_q <= {req.mcc, req.mnc, req.lac, req.cell_id, req.radio};
      now_q <= req.now_seconds;
      loc_q <= {req.latitude, req.longitude, req.range_m};
    end
  end

  // Issue one store read per cycle during the scan
  assign issue     = ctl.scan_run && (scan_addr < fill);
  assign tag_match = (tag_rd == tag_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else if (ctl.capture) begin
      scan_addr <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        scan_addr <= scan_addr + CW'(1);
      end
      if (pend && tag_match && !found) begin
        found <= 1'b1;
      end
    end
  end

  // Track first match and oldest insertion time
  always_ff @(posedge clk) begin
    if (issue) begin
      addr_d <= scan_addr[AW-1:0];
    end
    if (pend && tag_match && !found) begin
      found_slot <= addr_d;
    end
    if (pend && ((addr_d == '0) || (ins_rd < best_time))) begin
      best_slot <= addr_d;
      best_time <= ins_rd;
    end
  end

  assign sts.scan_done = ctl.scan_run && !issue && !pend;

  // Choose the slot to write and the expiry
  always_comb begin
    if (capacity == '0) begin
      eff_cap = MW'(1);
    end else if (MW'(capacity) > MW'(cltc_pkg::ENTRIES)) begin
      eff_cap = MW'(cltc_pkg::ENTRIES);
    end else begin
      eff_cap = MW'(capacity);
    end
    take_new = !found && (MW'(fill) < eff_cap);
    if (found) begin
      wr_slot = found_slot;
    end else if (take_new) begin
      wr_slot = fill[AW-1:0];
    end else begin
      wr_slot = best_slot;
    end
    exp_sum = {1'b0, now_q} + {1'b0, ttl};
    exp_val = exp_sum[cltc_pkg::TIME_W] ? '1 : exp_sum[cltc_pkg::TIME_W-1:0];
    we      = ctl.finish && (op_q == cltc_pkg::OP_INSERT);
    lk_hit  = found && (now_q <= exp_rd);
  end

  // Advance the fill count on a new slot
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (we && take_new) begin
      fill <= fill + CW'(1);
    end
  end

  // Slot stores
  cltc_ram #(.WIDTH(cltc_pkg::TAG_W), .DEPTH(cltc_pkg::ENTRIES)) u_tag_ram (
    .clk(clk), .we(we), .waddr(wr_slot), .wdata(tag_q),
    .raddr(scan_addr[AW-1:0]), .rdata(tag_rd)
  );

  cltc_ram #(.WIDTH(cltc_pkg::TIME_W), .DEPTH(cltc_pkg::ENTRIES)) u_ins_ram (
    .clk(clk), .we(we), .waddr(wr_slot), .wdata(now_q),
    .raddr(scan_addr[AW-1:0]), .rdata(ins_rd)
  );

  cltc_ram #(.WIDTH(cltc_pkg::TIME_W), .DEPTH(cltc_pkg::ENTRIES)) u_exp_ram (
    .clk(clk), .we(we), .waddr(wr_slot), .wdata(exp_val),
    .raddr(found_slot), .rdata(exp_rd)
  );

  cltc_ram #(.WIDTH(cltc_pkg::LOC_W), .DEPTH(cltc_pkg::ENTRIES)) u_loc_ram (
    .clk(clk), .we(we), .waddr(wr_slot), .wdata(loc_q),
    .raddr(found_slot), .rdata(loc_rd)
  );

  // Response register: load on commit, drop on transfer
  assign sts.out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (op_q == cltc_pkg::OP_INSERT) begin
        out_hit  <= 1'b1;
        out_loc  <= loc_q;
        out_slot <= cltc_pkg::SLOT_W'(wr_slot);
      end else if (lk_hit) begin
        out_hit  <= 1'b1;
        out_loc  <= loc_rd;
        out_slot <= cltc_pkg::SLOT_W'(found_slot);
      end else begin
        out_hit  <= 1'b0;
        out_loc  <= '0;
        out_slot <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hit   = out_hit;
  assign {rsp.hit_latitude, rsp.hit_longitude, rsp.hit_range_m} = out_loc;
  assign rsp.slot  = out_slot;
  assign req.ready = ctl.in_ready;

endmodule
`default_nettype wire
